>>> hdl/assert_macros.svh
// assertion helpers, clocked on clock and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_SAME(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hdl/mbsp_pkg.sv
package mbsp_pkg;

   localparam int ByteW  = 8;
   localparam int DataW  = 7;
   localparam int ChanW  = 4;
   localparam int KindW  = 3;
   localparam int CountW = 2;

   // event kinds on rsp_tuser
   localparam logic [KindW-1:0] KIND_NOTE_OFF  = 3'd0;
   localparam logic [KindW-1:0] KIND_NOTE_ON   = 3'd1;
   localparam logic [KindW-1:0] KIND_CTRL      = 3'd2;
   localparam logic [KindW-1:0] KIND_BEND      = 3'd3;
   localparam logic [KindW-1:0] KIND_SYS_RESET = 3'd4;

   // csr indexes
   localparam logic CSR_OMNI   = 1'b0;
   localparam logic CSR_LISTEN = 1'b1;

   // status bytes and nibbles
   localparam logic [ByteW-1:0] STAT_SYS_RESET = 8'hFF;
   localparam logic [ByteW-1:0] STAT_MTC       = 8'hF1;
   localparam logic [ByteW-1:0] STAT_SONG_POS  = 8'hF2;
   localparam logic [ByteW-1:0] STAT_SONG_SEL  = 8'hF3;
   localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
   localparam logic [3:0] HI_NOTE_ON   = 4'h9;
   localparam logic [3:0] HI_POLY_AT   = 4'hA;
   localparam logic [3:0] HI_CTRL      = 4'hB;
   localparam logic [3:0] HI_PROG      = 4'hC;
   localparam logic [3:0] HI_CHAN_AT   = 4'hD;
   localparam logic [3:0] HI_BEND      = 4'hE;

   // count value that never completes a message
   localparam logic [CountW-1:0] NEVER_DONE = 2'd3;

   // data bytes expected after a status byte
   function automatic logic [CountW-1:0] length_for_status(input logic [ByteW-1:0] b);
      logic [CountW-1:0] len;
      len = NEVER_DONE;
      case (b[7:4])
         HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_BEND: len = 2'd2;
         HI_PROG, HI_CHAN_AT: len = 2'd1;
         default: begin
            if (b == STAT_MTC || b == STAT_SONG_SEL)
               len = 2'd1;
            else if (b == STAT_SONG_POS)
               len = 2'd2;
            else
               len = NEVER_DONE;
         end
      endcase
      return len;
   endfunction

endpackage

>>> hdl/midi_byte_stream_parser.sv
// channel | dir | handshake        | payload
// req     | in  | tvalid / tready  | tdata[7:0] rx_byte
// rsp     | out | tvalid / tready  | tuser[2:0] event_kind, tdata channel/data
// csr     | in  | csr_wr_en        | csr_index selects register, csr_wdata value
//
// one byte per clock sustained while results are taken: a byte is held in the
// input register, and the decode between it and the result register is
// combinational; rsp_tvalid is driven from the result register
// a held result stalls the input register only, so req_tready drops only
// when both registers are full and rsp_tready is low
// reset is synchronous: parser state goes to no running status, omni on

`include "assert_macros.svh"

module midi_byte_stream_parser (
   input  logic        clock,
   input  logic        reset,
   // req: rx_byte [7:0]
   input  logic [7:0]  req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp: event_channel [3:0], first_data [10:4], second_data [17:11], zero fill
   output logic [23:0] rsp_tdata,
   // rsp: event_kind [2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   // config registers
   logic       omni_ff, omni_in;
   logic [3:0] listen_ff, listen_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // parser state
   logic [7:0] status_ff, status_in;
   logic [1:0] expect_ff, expect_in;
   logic [1:0] seen_ff, seen_in;
   logic [6:0] held_ff, held_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_kind_ff, out_kind_in;
   logic [3:0] out_chan_ff, out_chan_in;
   logic [6:0] out_first_ff, out_first_in;
   logic [6:0] out_second_ff, out_second_in;

   logic       out_free;
   logic       advance;
   logic       emit;
   logic [1:0] seen_inc;
   logic       complete;
   logic       chan_ok;
   logic       kind_ok;
   logic [2:0] kind;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // csr writes
   always_comb begin
      omni_in   = omni_ff;
      listen_in = listen_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mbsp_pkg::CSR_OMNI:   omni_in   = csr_wdata[0];
            mbsp_pkg::CSR_LISTEN: listen_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // input register load
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   // data count saturates at three
   assign seen_inc = (seen_ff == 2'd3) ? 2'd3 : seen_ff + 2'd1;
   assign complete = (expect_ff != mbsp_pkg::NEVER_DONE) && (seen_inc >= expect_ff);
   assign chan_ok  = omni_ff || (status_ff[3:0] == listen_ff);

   // event kind from the running status
   always_comb begin
      kind    = mbsp_pkg::KIND_NOTE_OFF;
      kind_ok = 1'b1;
      case (status_ff[7:4])
         mbsp_pkg::HI_NOTE_OFF: kind = mbsp_pkg::KIND_NOTE_OFF;
         mbsp_pkg::HI_NOTE_ON:
            kind = (in_byte_ff == 8'd0) ? mbsp_pkg::KIND_NOTE_OFF : mbsp_pkg::KIND_NOTE_ON;
         mbsp_pkg::HI_CTRL:     kind = mbsp_pkg::KIND_CTRL;
         mbsp_pkg::HI_BEND:     kind = mbsp_pkg::KIND_BEND;
         default:               kind_ok = 1'b0;
      endcase
   end

   // parser step for the byte in the input register
   always_comb begin
      status_in     = status_ff;
      expect_in     = expect_ff;
      seen_in       = seen_ff;
      held_in       = held_ff;
      emit          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_chan_in   = out_chan_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      if (advance) begin
         if (in_byte_ff == mbsp_pkg::STAT_SYS_RESET) begin
            // system reset drops running status and reports itself
            status_in     = 8'd0;
            expect_in     = mbsp_pkg::NEVER_DONE;
            seen_in       = 2'd0;
            emit          = 1'b1;
            out_kind_in   = mbsp_pkg::KIND_SYS_RESET;
            out_chan_in   = 4'd0;
            out_first_in  = 7'd0;
            out_second_in = 7'd0;
         end else if (in_byte_ff[7]) begin
            status_in = in_byte_ff;
            expect_in = mbsp_pkg::length_for_status(in_byte_ff);
            seen_in   = 2'd0;
         end else begin
            seen_in = seen_inc;
            if (seen_inc == 2'd1)
               held_in = in_byte_ff[6:0];
            if (complete && chan_ok && kind_ok) begin
               // full message: report it and restart the count for running status
               seen_in       = 2'd0;
               emit          = 1'b1;
               out_kind_in   = kind;
               out_chan_in   = status_ff[3:0];
               out_first_in  = (seen_inc == 2'd1) ? in_byte_ff[6:0] : held_ff;
               out_second_in = in_byte_ff[6:0];
            end
         end
      end
   end

   // result register: loads on an emitting step, clears once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance)
         out_valid_in = emit;
      else if (rsp_tready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         omni_ff      <= 1'b1;
         listen_ff    <= 4'd0;
         in_valid_ff  <= 1'b0;
         status_ff    <= 8'd0;
         expect_ff    <= mbsp_pkg::NEVER_DONE;
         seen_ff      <= 2'd0;
         held_ff      <= 7'd0;
         out_valid_ff <= 1'b0;
      end else begin
         omni_ff      <= omni_in;
         listen_ff    <= listen_in;
         in_valid_ff  <= in_valid_in;
         status_ff    <= status_in;
         expect_ff    <= expect_in;
         seen_ff      <= seen_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      out_kind_ff   <= out_kind_in;
      out_chan_ff   <= out_chan_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {6'd0, out_second_ff, out_first_ff, out_chan_ff};

   `ASSERT_SAME(a_expect_nonzero, 1'b1, expect_ff != 2'd0, "expected count is zero")
   `ASSERT_NEXT(a_sysreset_clears,
      advance && in_byte_ff == mbsp_pkg::STAT_SYS_RESET,
      status_ff == 8'd0 && expect_ff == mbsp_pkg::NEVER_DONE && seen_ff == 2'd0 &&
      out_valid_ff && out_kind_ff == mbsp_pkg::KIND_SYS_RESET,
      "system reset did not clear running status")
   `ASSERT_NEXT(a_status_restarts_count, advance && in_byte_ff[7], seen_ff == 2'd0,
      "status byte left a data count")
   `ASSERT_SAME(a_sysreset_payload_zero,
      out_valid_ff && out_kind_ff == mbsp_pkg::KIND_SYS_RESET,
      out_chan_ff == 4'd0 && out_first_ff == 7'd0 && out_second_ff == 7'd0,
      "system reset event carries data")
   `ASSERT_NEXT(a_held_result_blocks, out_valid_ff && !rsp_tready && in_valid_ff,
      in_valid_ff, "input byte lost while result held")

endmodule

>>> sim/tb_midi_byte_stream_parser.sv
`timescale 1ns / 1ps

module tb_midi_byte_stream_parser;

   // status bytes with no data of their own
   localparam logic [7:0] RT_FIRST    = 8'hF8;
   localparam logic [7:0] RT_LAST     = 8'hFE;
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;

   // one parsed midi event as it leaves the block
   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] chan;
      logic [6:0] first;
      logic [6:0] second;
   } midi_event_type;

   // tracks the running status parser and the events it owes
   class midi_event_tracker;
      logic           omni;
      logic [3:0]     listen;
      logic [7:0]     status;
      logic [1:0]     need;
      logic [1:0]     seen;
      logic [6:0]     held;
      midi_event_type owed_events[$];
      int             mismatches;

      function new();
         omni       = 1'b1;
         listen     = 4'd0;
         status     = 8'd0;
         need       = mbsp_pkg::NEVER_DONE;
         seen       = 2'd0;
         held       = 7'd0;
         mismatches = 0;
      endfunction

      function void set_reg(logic idx, logic [3:0] value);
         if (idx == mbsp_pkg::CSR_OMNI)
            omni = value[0];
         else
            listen = value;
      endfunction

      // data bytes a status byte asks for
      function logic [1:0] data_length(logic [7:0] b);
         case (b[7:4])
            mbsp_pkg::HI_NOTE_OFF, mbsp_pkg::HI_NOTE_ON, mbsp_pkg::HI_POLY_AT,
            mbsp_pkg::HI_CTRL, mbsp_pkg::HI_BEND: return 2'd2;
            mbsp_pkg::HI_PROG, mbsp_pkg::HI_CHAN_AT: return 2'd1;
            default: begin
               if (b == mbsp_pkg::STAT_MTC || b == mbsp_pkg::STAT_SONG_SEL) return 2'd1;
               if (b == mbsp_pkg::STAT_SONG_POS) return 2'd2;
               return mbsp_pkg::NEVER_DONE;
            end
         endcase
      endfunction

      function void take_byte(logic [7:0] b);
         midi_event_type ev;
         if (b == mbsp_pkg::STAT_SYS_RESET) begin
            status = 8'd0;
            need   = mbsp_pkg::NEVER_DONE;
            seen   = 2'd0;
            owed_events.push_back(midi_event_type'{mbsp_pkg::KIND_SYS_RESET, 4'd0,
                                                   7'd0, 7'd0});
            return;
         end
         if (b[7]) begin
            status = b;
            need   = data_length(b);
            seen   = 2'd0;
            return;
         end
         if (seen != 2'd3)
            seen++;
         if (seen == 2'd1)
            held = b[6:0];
         if (need == mbsp_pkg::NEVER_DONE || seen < need)
            return;
         if (!(omni || status[3:0] == listen))
            return;
         case (status[7:4])
            mbsp_pkg::HI_NOTE_OFF: ev.kind = mbsp_pkg::KIND_NOTE_OFF;
            mbsp_pkg::HI_NOTE_ON:
               ev.kind = (b == 8'd0) ? mbsp_pkg::KIND_NOTE_OFF : mbsp_pkg::KIND_NOTE_ON;
            mbsp_pkg::HI_CTRL:     ev.kind = mbsp_pkg::KIND_CTRL;
            mbsp_pkg::HI_BEND:     ev.kind = mbsp_pkg::KIND_BEND;
            default:               return;
         endcase
         seen      = 2'd0;
         ev.chan   = status[3:0];
         ev.first  = held;
         ev.second = b[6:0];
         owed_events.push_back(ev);
      endfunction

      task flag_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task match_event(midi_event_type got);
         midi_event_type want;
         if (owed_events.size() == 0) begin
            flag_mismatch($sformatf("unexpected event kind %0d ch %0d %0d %0d",
                                    got.kind, got.chan, got.first, got.second));
            return;
         end
         want = owed_events.pop_front();
         if (got.kind != want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.chan != want.chan)
            flag_mismatch($sformatf("channel %0d, want %0d", got.chan, want.chan));
         if (got.first != want.first)
            flag_mismatch($sformatf("first data %0d, want %0d", got.first, want.first));
         if (got.second != want.second)
            flag_mismatch($sformatf("second data %0d, want %0d", got.second, want.second));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] rsp_tdata;   // event_channel [3:0], first_data [10:4], second_data [17:11]
   logic [2:0]  rsp_tuser;   // event_kind [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_wr_en;
   logic        csr_index;
   logic [3:0]  csr_wdata;

   midi_event_tracker sb = new();

   int send_idle;   // percent of cycles the byte source holds off
   int recv_idle;   // percent of cycles the event sink stalls
   int sent;        // bytes transferred into the block so far

   midi_byte_stream_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // event sink: random stalls, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= recv_idle);
   end

   // every event transfer is checked against the oldest owed event
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.match_event(midi_event_type'{rsp_tuser, rsp_tdata[3:0], rsp_tdata[10:4],
                                         rsp_tdata[17:11]});
   end

   // one byte transfer, with a random hold-off in front of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      sb.take_byte(b);
      sent++;
   endtask

   // stop offering bytes, wait for owed events, then let the pipeline empty
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.owed_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [3:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic set_filter(input logic omni, input logic [3:0] chan);
      write_csr(mbsp_pkg::CSR_OMNI, {3'd0, omni});
      write_csr(mbsp_pkg::CSR_LISTEN, chan);
   endtask

   // channel message, repeated under running status, now and then broken
   task automatic send_voice_run();
      logic [3:0] hi;
      logic [3:0] ch;
      int         len;
      hi  = 4'($urandom_range(mbsp_pkg::HI_NOTE_OFF, mbsp_pkg::HI_BEND));
      ch  = (!sb.omni && $urandom_range(0, 1)) ? sb.listen : 4'($urandom_range(0, 15));
      len = (hi == mbsp_pkg::HI_PROG || hi == mbsp_pkg::HI_CHAN_AT) ? 1 : 2;
      send_byte({hi, ch});
      repeat ($urandom_range(1, 4)) begin
         for (int k = 0; k < len; k++) begin
            // real-time byte in the middle cancels running status
            if ($urandom_range(0, 99) < 3)
               send_byte(8'($urandom_range(RT_FIRST, RT_LAST)));
            if (k == len - 1 && $urandom_range(0, 99) < 15)
               send_byte(8'd0);
            else if ($urandom_range(0, 99) < 6)
               send_byte($urandom_range(0, 1) ? 8'd127 : 8'd0);
            else
               send_byte(8'($urandom_range(0, 127)));
         end
         // stray data byte starts a new running-status count, or pushes an uncleared count past the message length
         if ($urandom_range(0, 99) < 4)
            send_byte(8'($urandom_range(0, 127)));
      end
   endtask

   task automatic send_traffic(input int n);
      int stop_at;
      int pick;
      stop_at = sent + n;
      while (sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_voice_run();
         end else if (pick < 78) begin
            // system common status with one to three data bytes
            case ($urandom_range(0, 2))
               0: send_byte(mbsp_pkg::STAT_MTC);
               1: send_byte(mbsp_pkg::STAT_SONG_POS);
               default: send_byte(mbsp_pkg::STAT_SONG_SEL);
            endcase
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 127)));
         end else if (pick < 84) begin
            send_byte(SYSEX_START);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 127)));
            send_byte(SYSEX_END);
         end else if (pick < 89) begin
            send_byte(mbsp_pkg::STAT_SYS_RESET);
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
      drain();
   endtask

   initial begin
      logic [7:0] opening [];
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = mbsp_pkg::CSR_OMNI;
      csr_wdata  = 4'd0;
      send_idle  = 38;
      recv_idle  = 64;
      sent       = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed bytes under the reset filter (omni on)
      opening = '{
         {mbsp_pkg::HI_NOTE_ON, 4'd0}, 8'h3C, 8'h64,
         8'h3C, 8'h00,                          // running status, zero velocity
         {mbsp_pkg::HI_NOTE_OFF, 4'd15}, 8'h00, 8'h7F,
         {mbsp_pkg::HI_CTRL, 4'd5}, 8'h07, 8'h7F,
         {mbsp_pkg::HI_BEND, 4'd15}, 8'h7F, 8'h00,
         {mbsp_pkg::HI_POLY_AT, 4'd2}, 8'h10, 8'h20, 8'h30, // unsupported, count saturates
         {mbsp_pkg::HI_PROG, 4'd3}, 8'h05,
         mbsp_pkg::STAT_SONG_POS, 8'h01, 8'h02,
         RT_FIRST, 8'h15,                       // data with no usable status
         mbsp_pkg::STAT_SYS_RESET
      };
      foreach (opening[i])
         send_byte(opening[i]);
      drain();

      // channel filter: listened and foreign channel
      set_filter(1'b0, 4'd15);
      send_byte({mbsp_pkg::HI_NOTE_ON, 4'd15});
      send_byte(8'h40);
      send_byte(8'h40);
      send_byte({mbsp_pkg::HI_NOTE_ON, 4'd0});
      send_byte(8'h01);
      send_byte(8'h02);
      drain();
      // filter change while the foreign message is still counted
      set_filter(1'b0, 4'd0);
      send_byte(8'h03);
      drain();

      // random traffic over three idle profiles and several filters
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 38; recv_idle = 64; end
            1: begin send_idle = 64; recv_idle = 38; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         set_filter(1'b1, 4'd0);
         send_traffic(150);
         set_filter(1'b0, 4'd0);
         send_traffic(140);
         set_filter(1'b0, 4'd15);
         send_traffic(140);
         set_filter(1'b0, 4'($urandom_range(0, 15)));
         send_traffic(140);
      end

      repeat (10) @(posedge clock);
      if (sb.owed_events.size() != 0)
         sb.flag_mismatch($sformatf("%0d events never arrived", sb.owed_events.size()));
      if (sb.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hang guard
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> midi_byte_stream_parser.f
+incdir+hdl
hdl/mbsp_pkg.sv
hdl/midi_byte_stream_parser.sv
sim/tb_midi_byte_stream_parser.sv
